[sv/rfbg_pkg.sv]
// Shared types and constants of the raw frame to BGR or gray converter.
package rfbg_pkg;

	localparam int unsigned CFG_INDEX_W = 2;

	localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_FORMAT = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_KIND   = 2'd1;

	localparam logic FMT_BGR24  = 1'b0;
	localparam logic FMT_YUY2   = 1'b1;
	localparam logic KIND_COLOR = 1'b0;
	localparam logic KIND_GRAY  = 1'b1;

	localparam logic [1:0] MODE_BGR_COLOR = 2'd0;
	localparam logic [1:0] MODE_BGR_GRAY  = 2'd1;
	localparam logic [1:0] MODE_YUV_GRAY  = 2'd2;
	localparam logic [1:0] MODE_YUV_COLOR = 2'd3;

	typedef struct packed {
		logic       emit;
		logic [1:0] mode;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [7:0] b3;
	} job_t;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic [7:0] gray;
		logic       pair_last;
	} pixel_t;

endpackage

[sv/rfbg_unpack.sv]
// Byte phase tracking and byte holding that group raw bytes into pixel jobs.
module rfbg_unpack (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  logic [7:0]      data_byte,
	input  logic            frame_last,
	input  logic            source_format,
	input  logic            output_kind,
	output rfbg_pkg::job_t  job
);
	import rfbg_pkg::*;

	logic [1:0] phase_q;
	logic [7:0] held_q [3];
	logic [1:0] next_phase;
	logic       hold;

	always_comb begin
		job        = '0;
		job.b0     = held_q[0];
		job.b1     = held_q[1];
		job.b2     = data_byte;
		job.b3     = data_byte;
		hold       = 1'b0;
		next_phase = phase_q + 2'd1;
		if (source_format == FMT_BGR24) begin
			if (phase_q[1]) begin
				job.emit   = 1'b1;
				job.mode   = (output_kind == KIND_GRAY) ? MODE_BGR_GRAY : MODE_BGR_COLOR;
				next_phase = 2'd0;
			end else begin
				hold = 1'b1;
			end
		end else if (output_kind == KIND_GRAY) begin
			job.emit = ~phase_q[0];
			job.mode = MODE_YUV_GRAY;
			job.b0   = data_byte;
			hold     = (phase_q != 2'd3);
		end else if (phase_q == 2'd3) begin
			job.emit   = 1'b1;
			job.mode   = MODE_YUV_COLOR;
			job.b2     = held_q[2];
			next_phase = 2'd0;
		end else begin
			hold = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 2'd0;
		end else if (accept) begin
			phase_q <= frame_last ? 2'd0 : next_phase;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (accept && hold && (phase_q == 2'(i))) begin
				held_q[i] <= data_byte;
			end
		end
	end

endmodule

[sv/rfbg_convert.sv]
// Pixel arithmetic and the two-slot result register that feeds the output port.
module rfbg_convert (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	input  rfbg_pkg::job_t    job,
	input  logic              out_stall,
	output logic              load,
	output logic              out_valid,
	output rfbg_pkg::pixel_t  pixel
);
	import rfbg_pkg::*;

	function automatic logic [7:0] clamp8(input logic signed [19:0] s);
		logic [7:0] r;
		if (s[19]) begin
			r = 8'd0;
		end else if (|s[18:16]) begin
			r = 8'hFF;
		end else begin
			r = s[15:8];
		end
		return r;
	endfunction

	function automatic pixel_t yuv_pixel(input logic [7:0] y, input logic [7:0] u,
			input logic [7:0] v, input logic last);
		logic signed [9:0]  yc;
		logic signed [9:0]  d;
		logic signed [9:0]  e;
		logic signed [19:0] c;
		logic signed [19:0] sb;
		logic signed [19:0] sg;
		logic signed [19:0] sr;
		pixel_t             p;
		yc = $signed({2'b00, y}) - 10'sd16;
		d  = $signed({2'b00, u}) - 10'sd128;
		e  = $signed({2'b00, v}) - 10'sd128;
		c  = 20'sd298 * yc;
		sb = c + 20'sd516 * d + 20'sd128;
		sg = c - 20'sd100 * d - 20'sd208 * e + 20'sd128;
		sr = c + 20'sd409 * e + 20'sd128;
		p.blue      = clamp8(sb);
		p.green     = clamp8(sg);
		p.red       = clamp8(sr);
		p.gray      = 8'd0;
		p.pair_last = last;
		return p;
	endfunction

	pixel_t     pix0_s2;
	pixel_t     pix1_s2;
	logic [1:0] cnt_s2;
	pixel_t     new0;
	pixel_t     new1;
	logic [1:0] new_cnt;
	logic [9:0] gray_sum;
	logic       take;

	assign gray_sum = {2'b00, job.b0} + {1'b0, job.b1, 1'b0} + {2'b00, job.b2};

	always_comb begin
		new0    = '0;
		new1    = '0;
		new_cnt = 2'd1;
		new1.pair_last = 1'b1;
		case (job.mode)
			MODE_BGR_COLOR: begin
				new1.blue  = job.b0;
				new1.green = job.b1;
				new1.red   = job.b2;
			end
			MODE_BGR_GRAY: begin
				new1.gray = gray_sum[9:2];
			end
			MODE_YUV_GRAY: begin
				new1.gray = job.b0;
			end
			MODE_YUV_COLOR: begin
				new0    = yuv_pixel(job.b0, job.b1, job.b3, 1'b0);
				new1    = yuv_pixel(job.b2, job.b1, job.b3, 1'b1);
				new_cnt = 2'd2;
			end
			default: begin
				new_cnt = 2'd1;
			end
		endcase
	end

	assign out_valid = (cnt_s2 != 2'd0);
	assign pixel     = (cnt_s2 == 2'd2) ? pix0_s2 : pix1_s2;
	assign take      = out_valid && !out_stall;
	assign load      = job_valid && ((cnt_s2 == 2'd0) || ((cnt_s2 == 2'd1) && take));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s2 <= 2'd0;
		end else if (load) begin
			cnt_s2 <= new_cnt;
		end else if (take) begin
			cnt_s2 <= cnt_s2 - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pix0_s2 <= new0;
			pix1_s2 <= new1;
		end
	end

endmodule

[sv/raw_frame_to_bgr_or_gray_core.sv]
// Top level of the raw frame to BGR or gray pixel converter.
// The core takes one raw frame byte per cycle while out_stall is low and sustains that rate in
// every mode. A byte is captured in an input register together with the bytes held for its
// group, and the pixel math runs between that register and a two-slot result register, from
// which each pixel leaves. YUY2 color mode yields two pixels on every fourth byte; they leave
// one after the other, the second with pair_last set, and the core keeps taking bytes meanwhile.
// A downstream stall holds the result register first and then the input register, after which
// in_stall rises. Configuration writes are always accepted and take effect on the next byte.
module raw_frame_to_bgr_or_gray_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [7:0]                         data_byte,
	input  logic                               frame_last,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [7:0]                         blue,
	output logic [7:0]                         green,
	output logic [7:0]                         red,
	output logic [7:0]                         gray,
	output logic                               pair_last,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [rfbg_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic                               cfg_data
);
	import rfbg_pkg::*;

	logic   source_format_q;
	logic   output_kind_q;
	logic   in_accept;
	job_t   job;
	job_t   job_s1;
	logic   valid_s1;
	logic   load;
	pixel_t pixel;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_format_q <= FMT_BGR24;
			output_kind_q   <= KIND_COLOR;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SOURCE_FORMAT: source_format_q <= cfg_data;
				REG_OUTPUT_KIND:   output_kind_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign in_stall  = valid_s1 && !load;
	assign in_accept = in_valid && !in_stall;

	rfbg_unpack u_unpack (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (in_accept),
		.data_byte     (data_byte),
		.frame_last    (frame_last),
		.source_format (source_format_q),
		.output_kind   (output_kind_q),
		.job           (job)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_accept && job.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			job_s1 <= job;
		end
	end

	rfbg_convert u_convert (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (valid_s1),
		.job       (job_s1),
		.out_stall (out_stall),
		.load      (load),
		.out_valid (out_valid),
		.pixel     (pixel)
	);

	assign blue      = pixel.blue;
	assign green     = pixel.green;
	assign red       = pixel.red;
	assign gray      = pixel.gray;
	assign pair_last = pixel.pair_last;

`ifndef ASSERT_OFF
	a_load_needs_job: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> valid_s1)
		else $error("Result register loaded without a pending job.");

	a_stalled_job_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && in_stall) |=> valid_s1)
		else $error("A stalled job was lost from the input register.");

	a_no_result_from_nothing: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid && !load) |=> !out_valid)
		else $error("A result appeared without a transaction behind it.");
`endif

endmodule

[test/raw_frame_to_bgr_or_gray_core_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench that streams raw frame bytes through the converter in every mode.
module raw_frame_to_bgr_or_gray_core_test;
	import rfbg_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} raw_byte_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic [7:0]             data_byte = 8'd0;
	logic                   frame_last = 1'b0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [7:0]             blue;
	logic [7:0]             green;
	logic [7:0]             red;
	logic [7:0]             gray;
	logic                   pair_last;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic                   cfg_data = 1'b0;

	raw_byte_t  byte_q[$];
	pixel_t     pixels_due[$];
	logic       src_fmt = FMT_BGR24;
	logic       out_kind = KIND_COLOR;
	logic [1:0] phase = 2'd0;
	logic [7:0] held[3];
	int         bytes_taken = 0;
	int         errors = 0;
	logic       steady = 1'b0;
	logic       holding = 1'b0;

	raw_frame_to_bgr_or_gray_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.frame_last(frame_last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.blue(blue),
		.green(green),
		.red(red),
		.gray(gray),
		.pair_last(pair_last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic report_mismatch(string what);
		$display("mismatch at %0t: %s", $time, what);
		errors++;
	endtask

	function automatic pixel_t pack_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r,
			logic [7:0] gr, logic last);
		pixel_t p;
		p.blue = b;
		p.green = g;
		p.red = r;
		p.gray = gr;
		p.pair_last = last;
		return p;
	endfunction

	function automatic logic [7:0] clamp_chan(int s);
		if (s < 0)
			return 8'd0;
		if ((s >>> 8) > 255)
			return 8'd255;
		return s[15:8];
	endfunction

	function automatic pixel_t yuv_to_bgr(logic [7:0] y, logic [7:0] u, logic [7:0] v,
			logic last);
		int yi, ui, vi, c, d, e;
		yi = y;
		ui = u;
		vi = v;
		c = 298 * (yi - 16);
		d = ui - 128;
		e = vi - 128;
		return pack_pixel(clamp_chan(c + 516 * d + 128), clamp_chan(c - 100 * d - 208 * e + 128),
			clamp_chan(c + 409 * e + 128), 8'd0, last);
	endfunction

	// Advances the byte phase and queues the pixels that this byte completes.
	function automatic void convert_byte(logic [7:0] b, logic last);
		logic [1:0] ph;
		int gsum;
		ph = phase;
		if (src_fmt == FMT_BGR24) begin
			if (ph >= 2'd2) begin
				if (out_kind == KIND_COLOR) begin
					pixels_due.push_back(pack_pixel(held[0], held[1], b, 8'd0, 1'b1));
				end else begin
					gsum = held[0] + 2 * held[1] + b;
					pixels_due.push_back(pack_pixel(8'd0, 8'd0, 8'd0, gsum[9:2], 1'b1));
				end
				ph = 2'd0;
			end else begin
				held[ph] = b;
				ph = ph + 2'd1;
			end
		end else if (out_kind == KIND_GRAY) begin
			if (!ph[0])
				pixels_due.push_back(pack_pixel(8'd0, 8'd0, 8'd0, b, 1'b1));
			if (ph != 2'd3)
				held[ph] = b;
			ph = ph + 2'd1;
		end else if (ph == 2'd3) begin
			pixels_due.push_back(yuv_to_bgr(held[0], held[1], b, 1'b0));
			pixels_due.push_back(yuv_to_bgr(held[2], held[1], b, 1'b1));
			ph = 2'd0;
		end else begin
			held[ph] = b;
			ph = ph + 2'd1;
		end
		phase = last ? 2'd0 : ph;
	endfunction

	task automatic check_pixel();
		pixel_t want;
		if (pixels_due.size() == 0) begin
			report_mismatch("pixel arrived with none expected");
			return;
		end
		want = pixels_due.pop_front();
		if (blue !== want.blue)
			report_mismatch($sformatf("blue %0d, expected %0d", blue, want.blue));
		if (green !== want.green)
			report_mismatch($sformatf("green %0d, expected %0d", green, want.green));
		if (red !== want.red)
			report_mismatch($sformatf("red %0d, expected %0d", red, want.red));
		if (gray !== want.gray)
			report_mismatch($sformatf("gray %0d, expected %0d", gray, want.gray));
		if (pair_last !== want.pair_last)
			report_mismatch($sformatf("pair_last %0b, expected %0b", pair_last, want.pair_last));
	endtask

	always @(posedge clk or negedge arst_n) begin
		raw_byte_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				convert_byte(data_byte, frame_last);
				bytes_taken++;
			end
			if (!in_valid || !in_stall) begin
				if (byte_q.size() != 0 && (steady || $urandom_range(99) >= 25)) begin
					nxt = byte_q.pop_front();
					in_valid <= 1'b1;
					data_byte <= nxt.data;
					frame_last <= nxt.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall)
				check_pixel();
			out_stall <= holding || (!steady && $urandom_range(99) < 25);
		end
	end

	// The receiver blocks for a long stretch so that the core backs up and stalls its input.
	initial begin
		wait (bytes_taken >= 330);
		@(posedge clk);
		holding <= 1'b1;
		repeat (80) @(posedge clk);
		holding <= 1'b0;
	end

	initial begin
		#400000;
		$display("simulation failed");
		$finish;
	end

	task automatic push_byte(logic [7:0] d, logic l);
		byte_q.push_back({d, l});
	endtask

	function automatic logic [7:0] rand_byte();
		case ($urandom_range(7))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic wait_drained();
		do @(negedge clk); while (byte_q.size() != 0 || in_valid || pixels_due.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_SOURCE_FORMAT)
			src_fmt = val;
		else
			out_kind = val;
	endtask

	task automatic set_mode(logic fmt, logic kind);
		wait_drained();
		write_reg(REG_SOURCE_FORMAT, fmt);
		write_reg(REG_OUTPUT_KIND, kind);
		@(negedge clk);
	endtask

	// Mostly whole frames of complete groups, some with short or broken endings.
	task automatic queue_random_frames(int target, int group);
		int n, k, len;
		n = 0;
		while (n < target) begin
			if ($urandom_range(9) < 8) begin
				len = group * $urandom_range(1, 8);
				for (k = 0; k < len; k++)
					push_byte(rand_byte(), k == len - 1);
			end else begin
				len = $urandom_range(1, 12);
				for (k = 0; k < len; k++)
					push_byte(rand_byte(), k == len - 1 || $urandom_range(9) == 0);
			end
			n += len;
		end
		if ($urandom_range(1)) begin
			len = $urandom_range(1, 3);
			for (k = 0; k < len; k++)
				push_byte(rand_byte(), 1'b0);
		end
	endtask

	initial begin
		int p;
		logic fmt, kind;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		set_mode(FMT_BGR24, KIND_COLOR);
		push_byte(8'd0, 1'b0);
		push_byte(8'd255, 1'b0);
		push_byte(8'd0, 1'b0);
		push_byte(8'd255, 1'b0);
		push_byte(8'd7, 1'b1);

		set_mode(FMT_BGR24, KIND_GRAY);
		push_byte(8'd255, 1'b0);
		push_byte(8'd255, 1'b0);
		push_byte(8'd255, 1'b1);
		push_byte(8'd0, 1'b0);
		push_byte(8'd0, 1'b0);
		push_byte(8'd0, 1'b0);

		set_mode(FMT_YUY2, KIND_COLOR);
		push_byte(8'd255, 1'b0);
		push_byte(8'd0, 1'b0);
		push_byte(8'd255, 1'b0);
		push_byte(8'd255, 1'b0);
		push_byte(8'd0, 1'b0);
		push_byte(8'd255, 1'b0);
		push_byte(8'd0, 1'b0);
		push_byte(8'd0, 1'b0);
		push_byte(8'd9, 1'b1);

		// Leave a group open so the next format picks it up at its current position.
		set_mode(FMT_YUY2, KIND_GRAY);
		push_byte(8'd255, 1'b0);
		push_byte(8'd0, 1'b0);
		push_byte(8'd0, 1'b0);

		set_mode(FMT_BGR24, KIND_COLOR);
		push_byte(8'd128, 1'b1);

		for (p = 0; p < 8; p++) begin
			if (p < 4) begin
				fmt = p[1];
				kind = p[0];
			end else begin
				fmt = 1'($urandom_range(1));
				kind = 1'($urandom_range(1));
			end
			set_mode(fmt, kind);
			steady = (p == 5);
			queue_random_frames(125, fmt == FMT_YUY2 ? 4 : 3);
		end

		wait_drained();
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
